### hdl/levelset_voxel_update_defines.svh
// Assertion macros for the level-set voxel update block.
// Used by the top level only; needs i_clk and i_rst_n in scope.
`ifndef LEVELSET_VOXEL_UPDATE_DEFINES_SVH
`define LEVELSET_VOXEL_UPDATE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define LSVU_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define LSVU_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/lsvu_pkg.sv
// Package for the level-set voxel update: widths, payload structs,
// register indexes and the saturation helper. No dependencies.
`default_nettype none

package lsvu_pkg;

    localparam int DW = 32;          // data width
    localparam int FB = 16;          // fraction bits
    localparam int MW = 2 * DW;      // full product / radicand width
    localparam int RW = DW;          // root width
    localparam int QW = DW + 1;      // quotient bits worked out by the divider
    localparam int SW = MW + 2;      // width of sums of three products
    localparam int CFG_IDX_W = 3;

    localparam logic signed [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] SMIN = {1'b1, {(DW-1){1'b0}}};
    localparam logic signed [SW-1:0] SMAX_W = SW'(SMAX);
    localparam logic signed [SW-1:0] SMIN_W = SW'(SMIN);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ADV_WEIGHT  = CFG_IDX_W'(0),
        CFG_INFL_WEIGHT = CFG_IDX_W'(1),
        CFG_CURV_WEIGHT = CFG_IDX_W'(2),
        CFG_STEP_SIZE   = CFG_IDX_W'(3)
    } t_cfg_idx;

    typedef struct packed {
        logic signed [DW-1:0] phi_in;
        logic signed [DW-1:0] grad_x;
        logic signed [DW-1:0] grad_y;
        logic signed [DW-1:0] grad_z;
        logic signed [DW-1:0] edge_grad_x;
        logic signed [DW-1:0] edge_grad_y;
        logic signed [DW-1:0] edge_grad_z;
        logic signed [DW-1:0] edge_value;
        logic signed [DW-1:0] hj_flux;
        logic signed [DW-1:0] mean_curvature;
    } t_in;

    typedef struct packed {
        logic signed [DW-1:0] phi_out;
        logic                 zero_gradient;
        logic                 saturated;
    } t_out;

    // data riding alongside the root and quotient cells
    typedef struct packed {
        logic signed [DW-1:0] phi;
        logic signed [DW-1:0] infl;
        logic signed [DW-1:0] curv;
        logic [MW-1:0]        dot_mag;
        logic                 dot_neg;
        logic                 zero;
        logic                 ovf;
        logic                 clip;
    } t_side;

    typedef struct packed {
        logic signed [DW-1:0] value;
        logic                 clip;
    } t_sat;

    function automatic t_sat f_sat(input logic signed [SW-1:0] x);
        t_sat r;
        r.clip = 1'b1;
        if (x > SMAX_W) begin
            r.value = SMAX;
        end else if (x < SMIN_W) begin
            r.value = SMIN;
        end else begin
            r.value = x[DW-1:0];
            r.clip  = 1'b0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### hdl/lsvu_sqrt_cell.sv
// One cell of the integer square root chain: settles one root bit.
// Depends on lsvu_pkg.
`default_nettype none

module lsvu_sqrt_cell import lsvu_pkg::*; (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire logic [RW+1:0] i_rem,
    input  wire logic [RW-1:0] i_root,
    input  wire logic [MW-1:0] i_rad,
    input  wire t_side         i_side,
    output logic               o_valid,
    output logic [RW+1:0]      o_rem,
    output logic [RW-1:0]      o_root,
    output logic [MW-1:0]      o_rad,
    output t_side              o_side
);

    logic          r_valid;
    logic [RW+1:0] r_rem, n_rem;
    logic [RW-1:0] r_root, n_root;
    logic [MW-1:0] r_rad, n_rad;
    t_side         r_side;
    logic [RW+3:0] w_r2, w_trial;
    logic          w_ge;

    always_comb begin
        // bring down the next two radicand bits, try root*4+1
        w_r2    = {i_rem, i_rad[MW-1:MW-2]};
        w_trial = {2'b00, i_root, 2'b01};
        w_ge    = (w_r2 >= w_trial);
        n_rem   = w_ge ? (RW+2)'(w_r2 - w_trial) : (RW+2)'(w_r2);
        n_root  = {i_root[RW-2:0], w_ge};
        n_rad   = {i_rad[MW-3:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_root <= n_root;
            r_rad  <= n_rad;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_rad   = r_rad;
    assign o_side  = r_side;

endmodule

`default_nettype wire

### hdl/lsvu_div_cell.sv
// One cell of the restoring divider chain: settles one quotient bit.
// Depends on lsvu_pkg.
`default_nettype none

module lsvu_div_cell import lsvu_pkg::*; (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire logic [DW-1:0] i_rem,
    input  wire logic [QW-1:0] i_num,
    input  wire logic [QW-1:0] i_quo,
    input  wire logic [RW-1:0] i_den,
    input  wire t_side         i_side,
    output logic               o_valid,
    output logic [DW-1:0]      o_rem,
    output logic [QW-1:0]      o_num,
    output logic [QW-1:0]      o_quo,
    output logic [RW-1:0]      o_den,
    output t_side              o_side
);

    logic          r_valid;
    logic [DW-1:0] r_rem, n_rem;
    logic [QW-1:0] r_num, n_num;
    logic [QW-1:0] r_quo, n_quo;
    logic [RW-1:0] r_den;
    t_side         r_side;
    logic [DW:0]   w_r2, w_den;
    logic          w_ge;

    always_comb begin
        w_r2  = {i_rem, i_num[QW-1]};
        w_den = {1'b0, i_den};
        w_ge  = (w_r2 >= w_den);
        n_rem = w_ge ? DW'(w_r2 - w_den) : DW'(w_r2);
        n_num = {i_num[QW-2:0], 1'b0};
        n_quo = {i_quo[QW-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_num  <= n_num;
            r_quo  <= n_quo;
            r_den  <= i_den;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_num   = r_num;
    assign o_quo   = r_quo;
    assign o_den   = r_den;
    assign o_side  = r_side;

endmodule

`default_nettype wire

### hdl/levelset_voxel_update.sv
// Level-set voxel update: one explicit geodesic active contour step per voxel.
// Input beats carry one voxel (t_in), output beats one updated value (t_out).
// A config write port (valid/ready, always ready) sets the three weights and
// the step size; write it only while no voxel is in flight.
// Throughput: one voxel per cycle while the receiver does not stall. The chain is
// 2 product/sum stages, 32 square-root cells (one root bit each), 33 divider cells
// (one quotient bit each), 5 weighting stages and the output register.
// The whole chain moves on one enable: when the output register holds a beat
// and the receiver stalls, the chain freezes and the input is stalled; in any
// other cycle a new voxel can be taken.
// Reset (synchronous, active low) empties the chain and clears the config registers.
// Depends on lsvu_pkg, lsvu_sqrt_cell, lsvu_div_cell and the defines header.
`default_nettype none
`include "levelset_voxel_update_defines.svh"

module levelset_voxel_update import lsvu_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire t_in                  i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output t_out                      o_out_data,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [DW-1:0]        i_cfg_data
);

    logic w_en;

    // ---- configuration registers
    logic signed [DW-1:0] r_adv_w, r_infl_w, r_curv_w;
    logic [DW-2:0]        r_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_adv_w  <= '0;
            r_infl_w <= '0;
            r_curv_w <= '0;
            r_step   <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_ADV_WEIGHT:  r_adv_w  <= i_cfg_data;
                CFG_INFL_WEIGHT: r_infl_w <= i_cfg_data;
                CFG_CURV_WEIGHT: r_curv_w <= i_cfg_data;
                CFG_STEP_SIZE:   r_step   <= i_cfg_data[DW-2:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // ---- stage 1: products
    logic                 r_s1_valid;
    logic signed [MW-1:0] r_s1_sqx, r_s1_sqy, r_s1_sqz;
    logic signed [MW-1:0] r_s1_dx, r_s1_dy, r_s1_dz, r_s1_gh, r_s1_kh;
    logic signed [DW-1:0] r_s1_phi;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_sqx <= i_in_data.grad_x * i_in_data.grad_x;
            r_s1_sqy <= i_in_data.grad_y * i_in_data.grad_y;
            r_s1_sqz <= i_in_data.grad_z * i_in_data.grad_z;
            r_s1_dx  <= i_in_data.edge_grad_x * i_in_data.grad_x;
            r_s1_dy  <= i_in_data.edge_grad_y * i_in_data.grad_y;
            r_s1_dz  <= i_in_data.edge_grad_z * i_in_data.grad_z;
            r_s1_gh  <= i_in_data.edge_value * i_in_data.hj_flux;
            r_s1_kh  <= i_in_data.mean_curvature * i_in_data.hj_flux;
            r_s1_phi <= i_in_data.phi_in;
        end
    end

    // ---- stage 2: sums, magnitude squared, inflation and curvature terms
    logic [MW-1:0]        w_mag2;
    logic signed [SW-1:0] w_dot;
    t_sat                 w_infl, w_curv;
    t_side                w_s2_side;
    logic                 r_s2_valid;
    logic [MW-1:0]        r_s2_mag2;
    t_side                r_s2_side;

    always_comb begin
        w_mag2 = MW'($unsigned(r_s1_sqx)) + MW'($unsigned(r_s1_sqy))
               + MW'($unsigned(r_s1_sqz));
        w_dot  = SW'(r_s1_dx) + SW'(r_s1_dy) + SW'(r_s1_dz);
        w_infl = f_sat(SW'(r_s1_gh) >>> FB);
        w_curv = f_sat(SW'(r_s1_kh) >>> FB);
        w_s2_side.phi     = r_s1_phi;
        w_s2_side.infl    = w_infl.value;
        w_s2_side.curv    = w_curv.value;
        w_s2_side.dot_neg = w_dot[SW-1];
        w_s2_side.dot_mag = w_dot[SW-1] ? MW'(-w_dot) : MW'(w_dot);
        w_s2_side.zero    = (w_mag2 == '0);
        w_s2_side.ovf     = 1'b0;
        w_s2_side.clip    = w_infl.clip | w_curv.clip;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_mag2 <= w_mag2;
            r_s2_side <= w_s2_side;
        end
    end

    // ---- square root chain
    logic          sq_valid [0:RW];
    logic [RW+1:0] sq_rem   [0:RW];
    logic [RW-1:0] sq_root  [0:RW];
    logic [MW-1:0] sq_rad   [0:RW];
    t_side         sq_side  [0:RW];

    assign sq_valid[0] = r_s2_valid;
    assign sq_rem[0]   = '0;
    assign sq_root[0]  = '0;
    assign sq_rad[0]   = r_s2_mag2;
    assign sq_side[0]  = r_s2_side;

    for (genvar g = 0; g < RW; g++) begin : g_sqrt
        lsvu_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (sq_valid[g]),
            .i_rem   (sq_rem[g]),
            .i_root  (sq_root[g]),
            .i_rad   (sq_rad[g]),
            .i_side  (sq_side[g]),
            .o_valid (sq_valid[g+1]),
            .o_rem   (sq_rem[g+1]),
            .o_root  (sq_root[g+1]),
            .o_rad   (sq_rad[g+1]),
            .o_side  (sq_side[g+1])
        );
    end

    // ---- divider chain; the bits above the quotient flag overflow and seed the remainder
    logic          dv_valid [0:QW];
    logic [DW-1:0] dv_rem   [0:QW];
    logic [QW-1:0] dv_num   [0:QW];
    logic [QW-1:0] dv_quo   [0:QW];
    logic [RW-1:0] dv_den   [0:QW];
    t_side         dv_side  [0:QW];
    logic [DW-1:0] w_high;
    logic          w_ovf;

    always_comb begin
        w_high = {1'b0, sq_side[RW].dot_mag[MW-1:QW]};
        w_ovf  = (w_high >= sq_root[RW]);
        dv_side[0]     = sq_side[RW];
        dv_side[0].ovf = w_ovf;
        dv_rem[0]      = w_ovf ? '0 : w_high;
    end

    assign dv_valid[0] = sq_valid[RW];
    assign dv_num[0]   = sq_side[RW].dot_mag[QW-1:0];
    assign dv_quo[0]   = '0;
    assign dv_den[0]   = sq_root[RW];

    for (genvar g = 0; g < QW; g++) begin : g_div
        lsvu_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (dv_valid[g]),
            .i_rem   (dv_rem[g]),
            .i_num   (dv_num[g]),
            .i_quo   (dv_quo[g]),
            .i_den   (dv_den[g]),
            .i_side  (dv_side[g]),
            .o_valid (dv_valid[g+1]),
            .o_rem   (dv_rem[g+1]),
            .o_num   (dv_num[g+1]),
            .o_quo   (dv_quo[g+1]),
            .o_den   (dv_den[g+1]),
            .o_side  (dv_side[g+1])
        );
    end

    // ---- stage 3: advection term
    logic                 r_s3_valid;
    logic signed [DW-1:0] r_s3_adv, w_adv;
    t_side                r_s3_side, n_s3_side;
    logic                 w_adv_clip;
    logic [QW-1:0]        w_q;

    always_comb begin
        w_q        = dv_quo[QW];
        w_adv      = '0;
        w_adv_clip = 1'b0;
        if (dv_side[QW].zero) begin
            w_adv = '0;
        end else if (dv_side[QW].dot_neg) begin
            if (dv_side[QW].ovf || w_q > {1'b0, SMIN}) begin
                w_adv      = SMIN;
                w_adv_clip = 1'b1;
            end else begin
                w_adv = DW'(~w_q + 1'b1);
            end
        end else begin
            if (dv_side[QW].ovf || w_q > {1'b0, SMAX}) begin
                w_adv      = SMAX;
                w_adv_clip = 1'b1;
            end else begin
                w_adv = DW'(w_q);
            end
        end
        n_s3_side      = dv_side[QW];
        n_s3_side.clip = dv_side[QW].clip | w_adv_clip;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s3_adv  <= w_adv;
            r_s3_side <= n_s3_side;
        end
    end

    // ---- stage 4: weighted products
    logic                 r_s4_valid;
    logic signed [MW-1:0] r_s4_pa, r_s4_pi, r_s4_pc;
    t_side                r_s4_side;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s4_pa   <= r_adv_w * r_s3_adv;
            r_s4_pi   <= r_infl_w * r_s3_side.infl;
            r_s4_pc   <= r_curv_w * r_s3_side.curv;
            r_s4_side <= r_s3_side;
        end
    end

    // ---- stage 5: speed
    logic                 r_s5_valid;
    logic signed [DW-1:0] r_s5_speed;
    t_side                r_s5_side, n_s5_side;
    t_sat                 w_speed;

    always_comb begin
        w_speed = f_sat((SW'(r_s4_pa) + SW'(r_s4_pi) + SW'(r_s4_pc)) >>> FB);
        n_s5_side      = r_s4_side;
        n_s5_side.clip = r_s4_side.clip | w_speed.clip;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s5_speed <= w_speed.value;
            r_s5_side  <= n_s5_side;
        end
    end

    // ---- stage 6: step times speed
    logic                 r_s6_valid;
    logic signed [MW:0]   r_s6_prod;
    t_side                r_s6_side;
    logic signed [DW-1:0] w_step_s;

    assign w_step_s = {1'b0, r_step};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s6_prod <= w_step_s * r_s5_speed;
            r_s6_side <= r_s5_side;
        end
    end

    // ---- stage 7: scaled step
    logic                 r_s7_valid;
    logic signed [DW-1:0] r_s7_delta;
    t_side                r_s7_side, n_s7_side;
    t_sat                 w_delta;

    always_comb begin
        w_delta = f_sat(SW'(r_s6_prod) >>> FB);
        n_s7_side      = r_s6_side;
        n_s7_side.clip = r_s6_side.clip | w_delta.clip;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s7_delta <= w_delta.value;
            r_s7_side  <= n_s7_side;
        end
    end

    // ---- output register
    logic                 r_out_valid;
    t_out                 r_out;
    t_sat                 w_res;

    always_comb begin
        w_res = f_sat(SW'(r_s7_side.phi) - SW'(r_s7_delta));
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out.phi_out       <= w_res.value;
            r_out.zero_gradient <= r_s7_side.zero;
            r_out.saturated     <= r_s7_side.clip | w_res.clip;
        end
    end

    // ---- valid bits of the top-level stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_s5_valid  <= 1'b0;
            r_s6_valid  <= 1'b0;
            r_s7_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_s1_valid  <= i_in_valid;
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= dv_valid[QW];
            r_s4_valid  <= r_s3_valid;
            r_s5_valid  <= r_s4_valid;
            r_s6_valid  <= r_s5_valid;
            r_s7_valid  <= r_s6_valid;
            r_out_valid <= r_s7_valid;
        end
    end

    assign w_en        = !(r_out_valid && i_out_stall);
    assign o_in_stall  = !w_en;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ---- checks
    `LSVU_ASSERT_IMP(a_stall_only_when_full, o_in_stall, r_out_valid && i_out_stall, "input stalled while output free")
    `LSVU_ASSERT_NXT(a_accept_enters, i_in_valid && !o_in_stall, r_s1_valid, "accepted beat lost at entry")
    `LSVU_ASSERT_IMP(a_zero_root, sq_valid[RW] && sq_side[RW].zero, sq_root[RW] == '0, "nonzero root for zero gradient")
    `LSVU_ASSERT_IMP(a_zero_adv, r_s3_valid && r_s3_side.zero, r_s3_adv == '0, "advection kept for zero gradient")

endmodule

`default_nettype wire
